### design/ksmi_pkg.sv
// Shared types, constants and helpers for the key set membership intersection block.
package ksmi_pkg;

    localparam int MASK_W      = 64;
    localparam int KEY_W       = 32;
    localparam int LIMIT_W     = 6;
    localparam int INDEX_W     = 16;
    localparam int INDEX_FACTOR = 8;
    localparam int INDEX_BOUND  = 512;
    localparam int MAX_RESULTS  = 32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_RESULTS);

    localparam logic [2:0] KIND_CLEAR       = 3'd0;
    localparam logic [2:0] KIND_OBSERVE_SET = 3'd1;
    localparam logic [2:0] KIND_OBSERVE_KEY = 3'd2;
    localparam logic [2:0] KIND_UNREADABLE  = 3'd3;
    localparam logic [2:0] KIND_REPORT      = 3'd4;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_INDEX = 3'd1;
    localparam logic [2:0] STATUS_FULL      = 3'd2;
    localparam logic [2:0] STATUS_OVERFLOW  = 3'd3;
    localparam logic [2:0] STATUS_TOO_SMALL = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic [INDEX_W-1:0] set_index;
        logic [KEY_W-1:0]   object_key;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             key_valid;
        logic [KEY_W-1:0] safe_key;
        logic             last;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
    } entry_t;

    typedef struct packed {
        logic              ok;
        logic [MASK_W-1:0] mask;
    } index_dec_t;

    // A set index is usable when it is below the bound, on the spacing, and its
    // bit position fits in the mask.
    function automatic index_dec_t index_decode(logic [INDEX_W-1:0] idx);
        index_dec_t         dec;
        logic [INDEX_W-1:0] pos;
        pos      = INDEX_W'(idx / INDEX_FACTOR);
        dec.ok   = (idx < INDEX_W'(INDEX_BOUND)) && ((idx % INDEX_FACTOR) == '0)
                   && (pos < INDEX_W'(MASK_W));
        dec.mask = dec.ok ? (MASK_W'(1) << pos[5:0]) : '0;
        return dec;
    endfunction

endpackage

### design/key_set_membership_intersection.sv
// Top level of the key set membership intersection block with its sequencer.
//
// Usage: requests arrive on req (kind, set_index, object_key) under req_valid and
// req_stall; a request is taken at a clock edge with req_valid high and req_stall
// low. Results leave on rsp under rsp_valid and rsp_stall in the same way. The
// output_limit register is written through cfg_valid/cfg_ready/cfg_data; the user must
// write it only while the block is idle, which the block does not enforce. cfg_ready is always high.
// The block handles one request at a time and holds req_stall high until its last
// result has been placed in the output register. A table walk reads each entry in
// two steps (address, then compare) through the single RAM read port and the shared
// comparator. Clear, observe set and unreadable set reach the output register
// straight after decode, and a key lookup after a walk over at most the N stored
// keys; the next request is taken once the sequencer is back in idle. A report gives
// a status, possibly after a counting walk, or walks again to emit M keys in table
// order, the last with last set. Unused kinds give no result.
// When the receiver stalls, the output register holds its result and the
// sequencer waits with the next result; no result is lost or repeated.
// Reset empties the table, clears the observed mask and both flags, and sets
// output_limit to 32. The table RAM itself is not cleared; entries at or past
// the fill count are never read.
module key_set_membership_intersection #(
    parameter int KEY_CAPACITY = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  ksmi_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output ksmi_pkg::rsp_t                    rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ksmi_pkg::LIMIT_W-1:0]      cfg_data
);

    localparam int CNT_W  = $clog2(KEY_CAPACITY + 1);
    localparam int ADDR_W = KEY_CAPACITY > 1 ? $clog2(KEY_CAPACITY) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_COUNT = 2'd1;
    localparam logic [1:0] MODE_EMIT  = 2'd2;

    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     mode_reg, mode_next;
    logic [CNT_W-1:0]               scan_reg, scan_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               matches_reg, matches_next;
    logic [CNT_W-1:0]               emit_reg, emit_next;
    logic [ksmi_pkg::MASK_W-1:0]    observed_reg, observed_next;
    logic                           ovf_reg, ovf_next;
    logic                           unread_reg, unread_next;
    logic [ksmi_pkg::LIMIT_W-1:0]   limit_reg;
    ksmi_pkg::req_t                 item_reg;
    logic [ksmi_pkg::MASK_W-1:0]    bm_reg, bm_next;
    ksmi_pkg::rsp_t                 res_reg, res_next;

    ksmi_pkg::index_dec_t           dec;
    ksmi_pkg::entry_t               rd_entry;
    ksmi_pkg::entry_t               wr_entry;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic                           out_free;
    logic                           out_load;
    logic                           req_take;
    logic                           scan_last;
    logic                           hit;
    logic [CNT_W-1:0]               total;
    logic [ksmi_pkg::LIMIT_W-1:0]   limit_eff;

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign dec       = ksmi_pkg::index_decode(item_reg.set_index);
    assign scan_last = ((scan_reg + CNT_W'(1)) == count_reg);
    // The one comparator shared by key lookup, match counting and emission.
    assign hit       = (mode_reg == MODE_KEY) ? (rd_entry.key == item_reg.object_key)
                                              : (rd_entry.mask == observed_reg);
    assign total     = matches_reg + CNT_W'(hit);
    assign limit_eff = (limit_reg > ksmi_pkg::LIMIT_W'(ksmi_pkg::MAX_RESULTS))
                       ? ksmi_pkg::LIMIT_W'(ksmi_pkg::MAX_RESULTS) : limit_reg;
    assign out_load  = (state_reg == S_RESP) && out_free;

    ksmi_ram #(
        .WIDTH($bits(ksmi_pkg::entry_t)),
        .DEPTH(KEY_CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (scan_reg[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    ksmi_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (res_reg),
        .free      (out_free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        scan_next     = scan_reg;
        count_next    = count_reg;
        matches_next  = matches_reg;
        emit_next     = emit_reg;
        observed_next = observed_reg;
        ovf_next      = ovf_reg;
        unread_next   = unread_reg;
        bm_next       = bm_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[ADDR_W-1:0];
        wr_entry.key  = item_reg.object_key;
        wr_entry.mask = bm_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_next.status    = ksmi_pkg::STATUS_OK;
                res_next.key_valid = 1'b0;
                res_next.safe_key  = '0;
                res_next.last      = 1'b1;
                state_next         = S_RESP;
                unique case (item_reg.kind)
                    ksmi_pkg::KIND_CLEAR:
                    begin
                        observed_next = '0;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        unread_next   = 1'b0;
                    end
                    ksmi_pkg::KIND_OBSERVE_SET:
                    begin
                        if (!dec.ok)
                        begin
                            ovf_next        = 1'b1;
                            res_next.status = ksmi_pkg::STATUS_BAD_INDEX;
                        end
                        else
                        begin
                            observed_next = observed_reg | dec.mask;
                        end
                    end
                    ksmi_pkg::KIND_OBSERVE_KEY:
                    begin
                        if (!dec.ok)
                        begin
                            ovf_next        = 1'b1;
                            res_next.status = ksmi_pkg::STATUS_BAD_INDEX;
                        end
                        else
                        begin
                            observed_next = observed_reg | dec.mask;
                            bm_next       = dec.mask;
                            if (count_reg == '0)
                            begin
                                // Empty table: the key goes straight into the first entry.
                                wr_en         = 1'b1;
                                wr_entry.mask = dec.mask;
                                count_next    = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                mode_next  = MODE_KEY;
                                scan_next  = '0;
                                state_next = S_RD;
                            end
                        end
                    end
                    ksmi_pkg::KIND_UNREADABLE:
                    begin
                        unread_next = 1'b1;
                    end
                    ksmi_pkg::KIND_REPORT:
                    begin
                        if (ovf_reg)
                        begin
                            res_next.status = ksmi_pkg::STATUS_OVERFLOW;
                        end
                        else if (!unread_reg && (count_reg != '0))
                        begin
                            mode_next    = MODE_COUNT;
                            scan_next    = '0;
                            matches_next = '0;
                            state_next   = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_RD:
            begin
                state_next = S_CMP;
            end

            S_CMP:
            begin
                res_next.status    = ksmi_pkg::STATUS_OK;
                res_next.key_valid = 1'b0;
                res_next.safe_key  = '0;
                res_next.last      = 1'b1;
                unique case (mode_reg)
                    MODE_KEY:
                    begin
                        if (hit)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = scan_reg[ADDR_W-1:0];
                            wr_entry.mask = rd_entry.mask | bm_reg;
                            state_next    = S_RESP;
                        end
                        else if (scan_last)
                        begin
                            state_next = S_RESP;
                            if (count_reg == CNT_W'(KEY_CAPACITY))
                            begin
                                ovf_next        = 1'b1;
                                res_next.status = ksmi_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            scan_next  = scan_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    MODE_COUNT:
                    begin
                        matches_next = total;
                        if (scan_last)
                        begin
                            if (7'(total) > 7'(limit_eff))
                            begin
                                res_next.status = ksmi_pkg::STATUS_TOO_SMALL;
                                state_next      = S_RESP;
                            end
                            else if (total == '0)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                mode_next  = MODE_EMIT;
                                scan_next  = '0;
                                emit_next  = '0;
                                state_next = S_RD;
                            end
                        end
                        else
                        begin
                            scan_next  = scan_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    MODE_EMIT:
                    begin
                        if (hit)
                        begin
                            res_next.key_valid = 1'b1;
                            res_next.safe_key  = rd_entry.key;
                            res_next.last      = ((emit_reg + CNT_W'(1)) == matches_reg);
                            emit_next          = emit_reg + CNT_W'(1);
                            state_next         = S_RESP;
                        end
                        else
                        begin
                            scan_next  = scan_reg + CNT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_RESP:
            begin
                // Wait here until the output register can take the result.
                if (out_free)
                begin
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_reg + CNT_W'(1);
                        state_next = S_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= MODE_KEY;
            scan_reg     <= '0;
            count_reg    <= '0;
            matches_reg  <= '0;
            emit_reg     <= '0;
            observed_reg <= '0;
            ovf_reg      <= 1'b0;
            unread_reg   <= 1'b0;
            limit_reg    <= ksmi_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            scan_reg     <= scan_next;
            count_reg    <= count_next;
            matches_reg  <= matches_next;
            emit_reg     <= emit_next;
            observed_reg <= observed_next;
            ovf_reg      <= ovf_next;
            unread_reg   <= unread_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            item_reg <= req;
        end
        bm_reg  <= bm_next;
        res_reg <= res_next;
    end

endmodule

### design/ksmi_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module ksmi_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/ksmi_out_reg.sv
// Output register stage that holds one result until the receiver takes it.
module ksmi_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  ksmi_pkg::rsp_t load_data,
    output logic          free,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ksmi_pkg::rsp_t rsp
);

    logic           valid_reg;
    logic           valid_next;
    ksmi_pkg::rsp_t data_reg;

    // The stage can take a new result when empty or when its result leaves now.
    assign free = !valid_reg || !rsp_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule
